>>> design/battery_level_status_classifier_defines.svh
// assertion macros shared by the checker of the battery level status classifier
`ifndef BATTERY_LEVEL_STATUS_CLASSIFIER_DEFINES_SVH
`define BATTERY_LEVEL_STATUS_CLASSIFIER_DEFINES_SVH

// same-cycle implication, held off during reset
`define BLS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, held off during reset
`define BLS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/bls_pkg.sv
// types, codes and constants of the battery level status classifier
`timescale 1ns / 1ps

package bls_pkg;

	// register indexes on the configuration channel
	localparam int CfgIdxW = 3;
	localparam logic [CfgIdxW-1:0] REG_CRIT_MV  = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_LOW_MV   = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_CRIT_PCT = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_LOW_PCT  = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_V_EXP    = 3'd4;

	// capacity level codes
	localparam logic [2:0] LVL_UNKNOWN  = 3'd0;
	localparam logic [2:0] LVL_CRITICAL = 3'd1;
	localparam logic [2:0] LVL_LOW      = 3'd2;
	localparam logic [2:0] LVL_NORMAL   = 3'd3;
	localparam logic [2:0] LVL_FULL     = 3'd4;

	// battery status codes
	localparam logic [1:0] STS_UNKNOWN     = 2'd0;
	localparam logic [1:0] STS_CHARGING    = 2'd1;
	localparam logic [1:0] STS_DISCHARGING = 2'd2;
	localparam logic [1:0] STS_FULL        = 2'd3;

	// status and charger word bits
	localparam int BIT_INIT    = 7;
	localparam int BIT_FULL    = 5;
	localparam int BIT_DISCHG  = 6;
	localparam int BIT_ONLINE  = 15;

	localparam logic [15:0] PCT_FULL = 16'd100;

	// reset values of the registers
	localparam logic [15:0] RST_CRIT_MV  = 16'd9400;
	localparam logic [15:0] RST_LOW_MV   = 16'd9700;
	localparam logic [6:0]  RST_CRIT_PCT = 7'd0;
	localparam logic [6:0]  RST_LOW_PCT  = 7'd7;
	localparam logic [1:0]  RST_V_EXP    = 2'd0;

	localparam int UvW    = 36;
	localparam int ScaleW = 20;

	typedef struct packed {
		logic [15:0] crit_mv;
		logic [15:0] low_mv;
		logic [6:0]  crit_pct;
		logic [6:0]  low_pct;
		logic [1:0]  v_exp;
	} cfg_t;

	typedef struct packed {
		logic [2:0]     level;
		logic [1:0]     status;
		logic           online;
		logic [UvW-1:0] uv;
	} res_t;

	// millivolts to microvolts times ten to the exponent
	function automatic logic [ScaleW-1:0] uv_scale(input logic [1:0] e);
		logic [ScaleW-1:0] s;
		case (e)
			2'd0:    s = 20'd1000;
			2'd1:    s = 20'd10000;
			2'd2:    s = 20'd100000;
			default: s = 20'd1000000;
		endcase
		return s;
	endfunction

endpackage

>>> design/bls_classify.sv
// level, status, charger online and voltage scaling for one poll
`timescale 1ns / 1ps

module bls_classify (
	input  bls_pkg::cfg_t cfg,
	input  logic [15:0]   charger_word,
	input  logic          charger_valid,
	input  logic [15:0]   status_word,
	input  logic          status_valid,
	input  logic [15:0]   voltage_raw,
	input  logic          voltage_valid,
	input  logic [15:0]   charge_percent,
	input  logic          percent_valid,
	output bls_pkg::res_t res
);
	import bls_pkg::*;

	logic              is_crit;
	logic              is_low;
	logic [ScaleW-1:0] scale;
	logic [UvW-1:0]    product;
	logic [2:0]        level;
	logic [1:0]        status;
	logic              online;
	logic [UvW-1:0]    uv;

	// threshold compares, percent thresholds at full input width
	assign is_crit = (voltage_raw <= cfg.crit_mv) ||
		(charge_percent <= {9'd0, cfg.crit_pct});
	assign is_low = (voltage_raw <= cfg.low_mv) ||
		(charge_percent <= {9'd0, cfg.low_pct});

	// capacity level
	always_comb begin
		if (!voltage_valid || !percent_valid) begin
			level = LVL_UNKNOWN;
		end else if (is_crit) begin
			level = LVL_CRITICAL;
		end else if (is_low) begin
			level = LVL_LOW;
		end else if (charge_percent < PCT_FULL) begin
			level = LVL_NORMAL;
		end else if (charge_percent == PCT_FULL) begin
			level = LVL_FULL;
		end else begin
			level = LVL_UNKNOWN;
		end
	end

	// status word decode
	always_comb begin
		if (!status_valid || !status_word[BIT_INIT]) begin
			status = STS_UNKNOWN;
		end else if (status_word[BIT_FULL]) begin
			status = STS_FULL;
		end else if (status_word[BIT_DISCHG]) begin
			status = STS_DISCHARGING;
		end else begin
			status = STS_CHARGING;
		end
	end

	assign online = charger_valid && charger_word[BIT_ONLINE];

	// one 16 by 20 multiply
	assign scale   = uv_scale(cfg.v_exp);
	assign product = {{(UvW-16){1'b0}}, voltage_raw} * {{(UvW-ScaleW){1'b0}}, scale};
	assign uv      = voltage_valid ? product : '0;

	assign res = {level, status, online, uv};

endmodule

>>> design/battery_level_status_classifier.sv
// battery level status classifier: one poll of battery readings in, one report out
//
// Input beats on s_* carry one poll: the charger state word, the status word,
// the voltage and the charge percent, each with a read-ok flag in s_tuser.
// Output beats on m_* carry the capacity level, battery status, report event,
// charger online bit, scaled voltage and the two known flags in m_tuser.
// Thresholds and the voltage exponent are written on the cfg_* channel, which
// is always ready; write it only while no poll is in flight.
// An accepted input beat reaches m_tvalid through the input register, then the
// result register after the compares and the 16 by 20 multiply. One poll is
// accepted every cycle while the output side takes beats.
// When m_tready is low the result register holds; the input register still
// takes one more beat, and s_tready drops only when both stages are full.
// Reset clears both stages, loads the register defaults and sets the previous
// poll memory to a valid zero charger word and an unknown level.
`timescale 1ns / 1ps

module battery_level_status_classifier (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// charger_word, status_word, voltage_raw, charge_percent
	input  logic [63:0]                  s_tdata,
	// charger_valid, status_valid, voltage_valid, percent_valid
	input  logic [3:0]                   s_tuser,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// charge_level, battery_status, report_event, charger_online,
	// voltage_microvolts, zero fill
	output logic [47:0]                  m_tdata,
	// charger_known, voltage_known
	output logic [1:0]                   m_tuser,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [bls_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [15:0]                  cfg_data
);
	import bls_pkg::*;

	cfg_t        cfg_q;
	logic        valid_s1;
	logic [63:0] data_s1;
	logic [3:0]  flags_s1;
	logic        valid_s2;
	res_t        res_s2;
	logic        event_s2;
	logic        cknown_s2;
	logic        vknown_s2;
	logic        last_cvalid_q;
	logic [15:0] last_cword_q;
	logic [2:0]  last_level_q;
	res_t        res;
	logic        adv;
	logic        take;
	logic        changed;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.crit_mv  <= RST_CRIT_MV;
			cfg_q.low_mv   <= RST_LOW_MV;
			cfg_q.crit_pct <= RST_CRIT_PCT;
			cfg_q.low_pct  <= RST_LOW_PCT;
			cfg_q.v_exp    <= RST_V_EXP;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_CRIT_MV:  cfg_q.crit_mv  <= cfg_data;
				REG_LOW_MV:   cfg_q.low_mv   <= cfg_data;
				REG_CRIT_PCT: cfg_q.crit_pct <= cfg_data[6:0];
				REG_LOW_PCT:  cfg_q.low_pct  <= cfg_data[6:0];
				REG_V_EXP:    cfg_q.v_exp    <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// pipeline flow
	assign adv      = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || adv;
	assign take     = s_tvalid && s_tready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			data_s1  <= s_tdata;
			flags_s1 <= s_tuser;
		end
	end

	bls_classify u_classify (
		.cfg            (cfg_q),
		.charger_word   (data_s1[15:0]),
		.charger_valid  (flags_s1[0]),
		.status_word    (data_s1[31:16]),
		.status_valid   (flags_s1[1]),
		.voltage_raw    (data_s1[47:32]),
		.voltage_valid  (flags_s1[2]),
		.charge_percent (data_s1[63:48]),
		.percent_valid  (flags_s1[3]),
		.res            (res)
	);

	// change against the previous poll; failed reads compare as one value
	assign changed = (flags_s1[0] != last_cvalid_q) ||
		(flags_s1[0] && (data_s1[15:0] != last_cword_q)) ||
		(res.level != last_level_q);

	// previous poll memory
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_cvalid_q <= 1'b1;
			last_cword_q  <= '0;
			last_level_q  <= LVL_UNKNOWN;
		end else if (valid_s1 && adv) begin
			last_cvalid_q <= flags_s1[0];
			last_cword_q  <= flags_s1[0] ? data_s1[15:0] : 16'd0;
			last_level_q  <= res.level;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv) begin
			res_s2    <= res;
			event_s2  <= changed;
			cknown_s2 <= flags_s1[0];
			vknown_s2 <= flags_s1[2];
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {5'd0, res_s2.uv, res_s2.online, event_s2, res_s2.status, res_s2.level};
	assign m_tuser  = {vknown_s2, cknown_s2};

endmodule

>>> design/bls_checker.sv
// port-level checks of the battery level status classifier, bound to the top level
`timescale 1ns / 1ps
`include "battery_level_status_classifier_defines.svh"

module bls_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata,
	input logic [1:0]  m_tuser
);
	import bls_pkg::*;

	// a stalled result beat holds
	`BLS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result beat changed while stalled")

	// input side stalls only behind a waiting result
	`BLS_ASSERT_NOW(a_stall_cause, !s_tready, m_tvalid, "input stalled with no result waiting")

	// level code within range
	`BLS_ASSERT_NOW(a_level_range, m_tvalid, m_tdata[2:0] <= LVL_FULL, "capacity level code out of range")

	// online only from a good charger read
	`BLS_ASSERT_NOW(a_online_known, m_tvalid && m_tdata[6], m_tuser[0], "charger online without a good charger read")

	// failed voltage read gives zero microvolts
	`BLS_ASSERT_NOW(a_uv_zero, m_tvalid && !m_tuser[1], m_tdata[42:7] == '0, "voltage nonzero after failed read")

endmodule

bind battery_level_status_classifier bls_checker u_bls_checker (.*);
